// File: rtl/mpts_pkg.sv
// Shared types and constants for the mesh point triangle search block.
package mpts_pkg;

	localparam int COORD_W   = 16;
	localparam int ENTRY_W   = 9;
	localparam int CORNER_W  = 8;
	localparam int TRINUM_W  = 9;
	localparam int VCOUNT_W  = 9;
	localparam int TCOUNT_W  = 10;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH    = 2;

	localparam logic [1:0] CMD_VERTEX   = 2'd0;
	localparam logic [1:0] CMD_TRIANGLE = 2'd1;
	localparam logic [1:0] CMD_QUERY    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_VERTEX,
		OP_TRIANGLE,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [ENTRY_W-1:0]         entry;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic [CORNER_W-1:0]        a;
		logic [CORNER_W-1:0]        b;
		logic [CORNER_W-1:0]        c;
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

// File: rtl/mesh_point_triangle_search_core.sv
// Top level of the mesh point triangle search: count registers, front end and back end.
// A table write is taken by the back end in the same cycle that it leaves the request queue.
// A query walks one triangle per cycle through a table read and sign-test pipeline,
// up to min(triangle_count, MAX_TRIANGLES) triangles, and stops early on a hit.
// A two-entry request queue keeps taking requests, until it is full, while a query walks or a result waits.
// Reset clears both counts and all control state; table contents stay undefined until written.
module mesh_point_triangle_search_core #(
	parameter int MAX_VERTICES  = 256,
	parameter int MAX_TRIANGLES = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mpts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpts_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [mpts_pkg::ENTRY_W-1:0]    entry,
	input  logic signed [mpts_pkg::COORD_W-1:0] coord_x,
	input  logic signed [mpts_pkg::COORD_W-1:0] coord_y,
	input  logic [mpts_pkg::CORNER_W-1:0]   corner_a,
	input  logic [mpts_pkg::CORNER_W-1:0]   corner_b,
	input  logic [mpts_pkg::CORNER_W-1:0]   corner_c,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [mpts_pkg::TRINUM_W-1:0]   tri_number,
	output logic [mpts_pkg::CORNER_W-1:0]   hit_a,
	output logic [mpts_pkg::CORNER_W-1:0]   hit_b,
	output logic [mpts_pkg::CORNER_W-1:0]   hit_c
);
	import mpts_pkg::*;

	logic [VCOUNT_W-1:0] vcount_q;
	logic [TCOUNT_W-1:0] tcount_q;
	logic                q_valid;
	req_t                q_req;
	logic                q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			tcount_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT:   vcount_q <= cfg_data[VCOUNT_W-1:0];
				CFG_TRIANGLE_COUNT: tcount_q <= cfg_data[TCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	mpts_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_TRIANGLES(MAX_TRIANGLES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.entry   (entry),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.q_valid (q_valid),
		.q_req   (q_req),
		.q_pop   (q_pop)
	);

	mpts_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_TRIANGLES(MAX_TRIANGLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_req         (q_req),
		.q_pop         (q_pop),
		.vertex_count  (vcount_q),
		.triangle_count(tcount_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.tri_number    (tri_number),
		.hit_a         (hit_a),
		.hit_b         (hit_b),
		.hit_c         (hit_c)
	);

endmodule

// File: rtl/mpts_front.sv
// Front end: accepts requests, drops the ones with no effect, queues the rest.
module mpts_front #(
	parameter int MAX_VERTICES  = 256,
	parameter int MAX_TRIANGLES = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [mpts_pkg::ENTRY_W-1:0]   entry,
	input  logic signed [mpts_pkg::COORD_W-1:0] coord_x,
	input  logic signed [mpts_pkg::COORD_W-1:0] coord_y,
	input  logic [mpts_pkg::CORNER_W-1:0]  corner_a,
	input  logic [mpts_pkg::CORNER_W-1:0]  corner_b,
	input  logic [mpts_pkg::CORNER_W-1:0]  corner_c,
	output logic                           q_valid,
	output mpts_pkg::req_t                 q_req,
	input  logic                           q_pop
);
	import mpts_pkg::*;

	req_t       fifo_q [QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	req_t       req_d;
	logic       keep;
	logic       push;

	always_comb begin
		req_d.entry = entry;
		req_d.x     = coord_x;
		req_d.y     = coord_y;
		req_d.a     = corner_a;
		req_d.b     = corner_b;
		req_d.c     = corner_c;
		req_d.op    = OP_QUERY;
		keep        = 1'b0;
		unique case (cmd)
			CMD_VERTEX: begin
				req_d.op = OP_VERTEX;
				keep     = 32'(entry) < 32'(MAX_VERTICES);
			end
			CMD_TRIANGLE: begin
				req_d.op = OP_TRIANGLE;
				keep     = 32'(entry) < 32'(MAX_TRIANGLES);
			end
			CMD_QUERY: begin
				req_d.op = OP_QUERY;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = (cnt_q == 2'(QDEPTH));
	// drop requests that change nothing
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= req_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: rtl/mpts_back.sv
// Back end: table memories, triangle walk pipeline and result register.
module mpts_back #(
	parameter int MAX_VERTICES  = 256,
	parameter int MAX_TRIANGLES = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  mpts_pkg::req_t                 q_req,
	output logic                           q_pop,
	input  logic [mpts_pkg::VCOUNT_W-1:0]  vertex_count,
	input  logic [mpts_pkg::TCOUNT_W-1:0]  triangle_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [mpts_pkg::TRINUM_W-1:0]  tri_number,
	output logic [mpts_pkg::CORNER_W-1:0]  hit_a,
	output logic [mpts_pkg::CORNER_W-1:0]  hit_b,
	output logic [mpts_pkg::CORNER_W-1:0]  hit_c
);
	import mpts_pkg::*;

	localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CWT = $clog2(MAX_TRIANGLES + 1);
	localparam int CW  = (CWT > TCOUNT_W) ? CWT : TCOUNT_W;
	localparam int DW  = COORD_W + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 1;
	localparam int NW  = PW + 3;

	logic [2*COORD_W-1:0]  vmem_a [MAX_VERTICES];
	logic [2*COORD_W-1:0]  vmem_b [MAX_VERTICES];
	logic [2*COORD_W-1:0]  vmem_c [MAX_VERTICES];
	logic [3*CORNER_W-1:0] tmem   [MAX_TRIANGLES];

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] limit;
	logic signed [COORD_W-1:0] px_q, py_q;

	logic vwr, twr, load_query, issue, finish_hit, finish_miss, load_out, busy;

	// walk pipeline
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [TRINUM_W-1:0]   idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [3*CORNER_W-1:0] tri_s1, cor_s2, cor_s3, cor_s4, cor_s5;
	logic [2*COORD_W-1:0]  va_s2, vb_s2, vc_s2;
	logic signed [DW-1:0]  dy12_s3, dx21_s3, dx02_s3, dy02_s3, dy20_s3, px_s3, py_s3;
	logic signed [PW-1:0]  m1_s4, m2_s4, m3_s4, m4_s4, m5_s4, m6_s4;
	logic signed [SW-1:0]  den_s5, na_s5, nb_s5;
	logic signed [NW-1:0]  nc;
	logic [CORNER_W-1:0]   ta, tb, tc;
	logic                  ok_s1, hit;
	logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;

	logic                  res_found_q;
	logic [TRINUM_W-1:0]   res_idx_q;
	logic [3*CORNER_W-1:0] res_cor_q;
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [TRINUM_W-1:0]   out_idx_q;
	logic [3*CORNER_W-1:0] out_cor_q;

	assign limit = (CW'(triangle_count) > CW'(MAX_TRIANGLES)) ?
		CW'(MAX_TRIANGLES) : CW'(triangle_count);

	assign ta = tri_s1[3*CORNER_W-1:2*CORNER_W];
	assign tb = tri_s1[2*CORNER_W-1:CORNER_W];
	assign tc = tri_s1[CORNER_W-1:0];

	function automatic logic corner_ok(input logic [CORNER_W-1:0] i,
		input logic [VCOUNT_W-1:0] vc);
		return (VCOUNT_W'(i) < vc) && (32'(i) < 32'(MAX_VERTICES));
	endfunction

	assign ok_s1 = corner_ok(ta, vertex_count) && corner_ok(tb, vertex_count) &&
		corner_ok(tc, vertex_count);

	assign ax = va_s2[2*COORD_W-1:COORD_W];
	assign ay = va_s2[COORD_W-1:0];
	assign bx = vb_s2[2*COORD_W-1:COORD_W];
	assign by = vb_s2[COORD_W-1:0];
	assign cx = vc_s2[2*COORD_W-1:COORD_W];
	assign cy = vc_s2[COORD_W-1:0];

	assign nc = NW'(den_s5) - NW'(na_s5) - NW'(nb_s5);

	always_comb begin
		if (den_s5 > 0) hit = (na_s5 >= 0) && (nb_s5 >= 0) && (nc >= 0);
		else if (den_s5 < 0) hit = (na_s5 <= 0) && (nb_s5 <= 0) && (nc <= 0);
		else hit = 1'b0;
		hit = hit && v_s5;
	end

	assign busy     = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign load_out = !out_valid_q || !out_stall;

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		vwr         = 1'b0;
		twr         = 1'b0;
		load_query  = 1'b0;
		issue       = 1'b0;
		finish_hit  = 1'b0;
		finish_miss = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_req.op)
						OP_VERTEX:   vwr = 1'b1;
						OP_TRIANGLE: twr = 1'b1;
						OP_QUERY: begin
							load_query = 1'b1;
							state_d    = ST_WALK;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				if (hit) begin
					finish_hit = 1'b1;
					state_d    = ST_DONE;
				end else if (cnt_q >= limit && !busy) begin
					finish_miss = 1'b1;
					state_d     = ST_DONE;
				end else begin
					issue = (cnt_q < limit);
				end
			end
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (vwr) begin
			vmem_a[VAW'(q_req.entry)] <= {q_req.x, q_req.y};
			vmem_b[VAW'(q_req.entry)] <= {q_req.x, q_req.y};
			vmem_c[VAW'(q_req.entry)] <= {q_req.x, q_req.y};
		end
		if (twr) tmem[TAW'(q_req.entry)] <= {q_req.a, q_req.b, q_req.c};
		tri_s1 <= tmem[cnt_q[TAW-1:0]];
		va_s2  <= vmem_a[VAW'(ta)];
		vb_s2  <= vmem_b[VAW'(tb)];
		vc_s2  <= vmem_c[VAW'(tc)];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_query) begin
			px_q <= q_req.x;
			py_q <= q_req.y;
		end
		idx_s1 <= cnt_q[TRINUM_W-1:0];
		idx_s2 <= idx_s1;
		cor_s2 <= tri_s1;
		idx_s3 <= idx_s2;
		cor_s3 <= cor_s2;
		dy12_s3 <= DW'(by) - DW'(cy);
		dx21_s3 <= DW'(cx) - DW'(bx);
		dx02_s3 <= DW'(ax) - DW'(cx);
		dy02_s3 <= DW'(ay) - DW'(cy);
		dy20_s3 <= DW'(cy) - DW'(ay);
		px_s3   <= DW'(px_q) - DW'(cx);
		py_s3   <= DW'(py_q) - DW'(cy);
		idx_s4 <= idx_s3;
		cor_s4 <= cor_s3;
		m1_s4  <= dy12_s3 * dx02_s3;
		m2_s4  <= dx21_s3 * dy02_s3;
		m3_s4  <= dy12_s3 * px_s3;
		m4_s4  <= dx21_s3 * py_s3;
		m5_s4  <= dy20_s3 * px_s3;
		m6_s4  <= dx02_s3 * py_s3;
		idx_s5 <= idx_s4;
		cor_s5 <= cor_s4;
		den_s5 <= SW'(m1_s4) + SW'(m2_s4);
		na_s5  <= SW'(m3_s4) + SW'(m4_s4);
		nb_s5  <= SW'(m5_s4) + SW'(m6_s4);
		if (finish_hit) begin
			res_found_q <= 1'b1;
			res_idx_q   <= idx_s5;
			res_cor_q   <= cor_s5;
		end else if (finish_miss) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			res_cor_q   <= '0;
		end
		if (state_q == ST_DONE && load_out) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
			out_cor_q   <= res_cor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_query) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + 1'b1;
			// flush what follows the first hit
			if (finish_hit) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				v_s4 <= 1'b0;
				v_s5 <= 1'b0;
			end else begin
				v_s1 <= issue;
				v_s2 <= v_s1 && ok_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
			if (state_q == ST_DONE && load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign tri_number = out_idx_q;
	assign hit_a      = out_cor_q[3*CORNER_W-1:2*CORNER_W];
	assign hit_b      = out_cor_q[2*CORNER_W-1:CORNER_W];
	assign hit_c      = out_cor_q[CORNER_W-1:0];

endmodule

// File: bench/mesh_point_triangle_search_core_test.sv
// Testbench for the mesh point triangle search core: directed and random requests, scored results.
module mesh_point_triangle_search_core_test;
	import mpts_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NUM_VERTS = 256;
	localparam int NUM_TRIS  = 512;
	localparam int DRAIN     = 600;

	typedef struct {
		logic                found;
		logic [TRINUM_W-1:0] tri_number;
		logic [CORNER_W-1:0] a;
		logic [CORNER_W-1:0] b;
		logic [CORNER_W-1:0] c;
	} answer_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 cmd;
	logic [ENTRY_W-1:0]         entry;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic [CORNER_W-1:0]        corner_a;
	logic [CORNER_W-1:0]        corner_b;
	logic [CORNER_W-1:0]        corner_c;
	logic                       out_valid;
	logic                       out_stall;
	logic                       found;
	logic [TRINUM_W-1:0]        tri_number;
	logic [CORNER_W-1:0]        hit_a;
	logic [CORNER_W-1:0]        hit_b;
	logic [CORNER_W-1:0]        hit_c;

	mesh_point_triangle_search_core dut (.*);

	// mirror of the block's tables and counts
	logic signed [COORD_W-1:0] vert_x [NUM_VERTS];
	logic signed [COORD_W-1:0] vert_y [NUM_VERTS];
	logic [CORNER_W-1:0]       tri_a [NUM_TRIS];
	logic [CORNER_W-1:0]       tri_b [NUM_TRIS];
	logic [CORNER_W-1:0]       tri_c [NUM_TRIS];
	int unsigned               vert_limit;
	int unsigned               tri_limit;

	answer_t pending_answers[$];
	int      mismatches;
	bit      idle_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#60_000_000;
		$display("mesh_point_triangle_search_core: mismatch");
		$finish;
	end

	function automatic bit point_inside(longint px0, longint py0, int i0, int i1, int i2);
		longint x0, y0, x1, y1, x2, y2, dy12, dx21, dx02, dy02, dy20, px, py, den, na, nb, nc;
		x0 = longint'(vert_x[i0]); y0 = longint'(vert_y[i0]);
		x1 = longint'(vert_x[i1]); y1 = longint'(vert_y[i1]);
		x2 = longint'(vert_x[i2]); y2 = longint'(vert_y[i2]);
		dy12 = y1 - y2; dx21 = x2 - x1; dx02 = x0 - x2; dy02 = y0 - y2; dy20 = y2 - y0;
		px = px0 - x2; py = py0 - y2;
		den = dy12 * dx02 + dx21 * dy02;
		na = dy12 * px + dx21 * py;
		nb = dy20 * px + dx02 * py;
		nc = den - na - nb;
		if (den == 0)
			return 1'b0;
		if (den > 0)
			return na >= 0 && nb >= 0 && nc >= 0;
		return na <= 0 && nb <= 0 && nc <= 0;
	endfunction

	function automatic answer_t locate_point(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py);
		answer_t r;
		int unsigned walk;
		r = '{1'b0, '0, '0, '0, '0};
		walk = (tri_limit > NUM_TRIS) ? NUM_TRIS : tri_limit;
		for (int t = 0; t < walk; t++) begin
			if (32'(tri_a[t]) >= vert_limit || 32'(tri_b[t]) >= vert_limit
					|| 32'(tri_c[t]) >= vert_limit)
				continue;
			if (point_inside(longint'(px), longint'(py), int'(tri_a[t]), int'(tri_b[t]),
					int'(tri_c[t]))) begin
				r = '{1'b1, TRINUM_W'(t), tri_a[t], tri_b[t], tri_c[t]};
				break;
			end
		end
		return r;
	endfunction

	task automatic send_req(logic [1:0] op, logic [ENTRY_W-1:0] addr,
			logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b, logic [CORNER_W-1:0] c);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= op; entry <= addr; coord_x <= x; coord_y <= y;
		corner_a <= a; corner_b <= b; corner_c <= c;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		case (op)
			CMD_VERTEX: begin
				if (addr < NUM_VERTS) begin
					vert_x[addr[7:0]] = x;
					vert_y[addr[7:0]] = y;
				end
			end
			CMD_TRIANGLE: begin
				tri_a[addr] = a; tri_b[addr] = b; tri_c[addr] = c;
			end
			CMD_QUERY: pending_answers.push_back(locate_point(x, y));
			default: ;
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		// a write may still be in flight behind the last result
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_counts(int unsigned vc, int unsigned tc);
		drain_results();
		cfg_we <= 1'b1; cfg_index <= CFG_VERTEX_COUNT; cfg_data <= CFG_W'(vc);
		@(posedge clk);
		cfg_index <= CFG_TRIANGLE_COUNT; cfg_data <= CFG_W'(tc);
		@(posedge clk);
		cfg_we <= 1'b0;
		vert_limit = vc & 9'h1FF;
		tri_limit = tc & 10'h3FF;
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
		send_req(CMD_QUERY, ENTRY_W'($urandom), x, y, CORNER_W'($urandom),
			CORNER_W'($urandom), CORNER_W'($urandom));
	endtask

	// point likely to land in a triangle: a corner, a centroid or anywhere
	task automatic send_mesh_query();
		int t, sx, sy;
		t = $urandom_range(0, NUM_TRIS - 1);
		case ($urandom_range(0, 3))
			0: send_query(vert_x[tri_a[t]], vert_y[tri_a[t]]);
			1: begin
				sx = (int'(vert_x[tri_a[t]]) + int'(vert_x[tri_b[t]])
					+ int'(vert_x[tri_c[t]])) / 3;
				sy = (int'(vert_y[tri_a[t]]) + int'(vert_y[tri_b[t]])
					+ int'(vert_y[tri_c[t]])) / 3;
				send_query(COORD_W'(sx), COORD_W'(sy));
			end
			default: send_query(pick_coord(), pick_coord());
		endcase
	endtask

	// both tables get written before any query can read them
	task automatic test_fill_tables();
		int a;
		for (int v = 0; v < NUM_VERTS; v++)
			send_req(CMD_VERTEX, ENTRY_W'(v), pick_coord(), pick_coord(), '0, '0, '0);
		for (int t = 0; t < NUM_TRIS; t++) begin
			a = $urandom_range(0, 255);
			if ($urandom_range(0, 15) == 0)
				send_req(CMD_TRIANGLE, ENTRY_W'(t), '0, '0, CORNER_W'(a), CORNER_W'(a),
					CORNER_W'($urandom));
			else
				send_req(CMD_TRIANGLE, ENTRY_W'(t), COORD_W'($urandom), COORD_W'($urandom),
					CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom));
		end
	endtask

	task automatic test_directed();
		set_counts(256, 512);
		send_query(vert_x[tri_a[0]], vert_y[tri_a[0]]);
		send_query(16'sh8000, 16'sh8000);
		send_query(16'sh7FFF, 16'sh7FFF);
		send_query(16'sh7FFF, 16'sh8000);
		send_query('0, '0);
		// degenerate triangle at entry 0, then query its single point
		send_req(CMD_TRIANGLE, 9'd0, '0, '0, 8'd5, 8'd5, 8'd5);
		send_query(vert_x[5], vert_y[5]);
		// out-of-range vertex write and unused command are dropped
		send_req(CMD_VERTEX, 9'd300, 16'sh1234, 16'sh4321, '0, '0, '0);
		send_req(CMD_UNUSED, 9'h1FF, 16'shFFFF, 16'shFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_req(CMD_TRIANGLE, 9'd511, '0, '0, 8'd0, 8'd255, 8'd128);
		send_query(vert_x[255], vert_y[255]);
		set_counts(0, 512);
		send_query(vert_x[tri_a[3]], vert_y[tri_a[3]]);
		set_counts(256, 0);
		send_query(vert_x[tri_a[3]], vert_y[tri_a[3]]);
		set_counts(511, 1023);
		send_query(vert_x[tri_a[511]], vert_y[tri_a[511]]);
		send_query(16'sh0010, 16'shFFF0);
	endtask

	task automatic test_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 70)
				send_mesh_query();
			else if (k < 85)
				send_req(CMD_VERTEX, ENTRY_W'($urandom), pick_coord(), pick_coord(),
					CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom));
			else if (k < 97)
				send_req(CMD_TRIANGLE, ENTRY_W'($urandom), pick_coord(), pick_coord(),
					CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom));
			else
				send_req(CMD_UNUSED, ENTRY_W'($urandom), pick_coord(), pick_coord(),
					CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom));
		end
	endtask

	task automatic test_back_pressure();
		for (int i = 0; i < 10; i++) begin
			send_mesh_query();
			in_valid <= 1'b0;
			@(posedge clk);
			while (pending_answers.size() != 0) @(posedge clk);
		end
	endtask

	// output stall: random hold before each result, none while idling is off
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_on ? $urandom_range(0, 7) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: found=%0d tri=%0d", found, tri_number);
			end else begin
				e = pending_answers.pop_front();
				if (found !== e.found || tri_number !== e.tri_number || hit_a !== e.a
						|| hit_b !== e.b || hit_c !== e.c) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
							e.found, e.tri_number, e.a, e.b, e.c,
							found, tri_number, hit_a, hit_b, hit_c);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_on = 1'b1;
		vert_limit = 0;
		tri_limit = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; cmd = '0; entry = '0; coord_x = '0; coord_y = '0;
		corner_a = '0; corner_b = '0; corner_c = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_tables();
		test_directed();
		set_counts(256, 512);
		test_random(150);
		idle_on = 1'b0;
		test_random(60);
		idle_on = 1'b1;
		set_counts(100, 50);
		test_random(80);
		set_counts(3, 1);
		test_random(30);
		set_counts(511, 1023);
		test_random(40);
		test_back_pressure();
		drain_results();
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("mesh_point_triangle_search_core: match");
		else
			$display("mesh_point_triangle_search_core: mismatch");
		$finish;
	end

endmodule
